[src/t2t_ndef_tlv_locator_core_assert.svh]
// assertion macros for the t2t ndef tlv locator
`ifndef T2T_NDEF_TLV_LOCATOR_CORE_ASSERT_SVH
`define T2T_NDEF_TLV_LOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define T2T_NTL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("t2t_ntl: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define T2T_NTL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("t2t_ntl: next-cycle check failed");

`endif

[src/t2t_ntl_pkg.sv]
// shared constants and types for the t2t ndef tlv locator
package t2t_ntl_pkg;

  localparam int MemBytesDef = 2048;
  localparam int HdrBytes    = 16;
  localparam int OffW        = 11;
  localparam int LenW        = 16;

  localparam logic [7:0] TagNull = 8'h00;
  localparam logic [7:0] TagTerm = 8'hFE;
  localparam logic [7:0] TagNdef = 8'h03;
  localparam logic [7:0] LongLen = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_MALF  = 2'd2,
    ST_BIG   = 2'd3
  } status_t;

  typedef struct packed {
    status_t             status;
    logic                ndef_found;
    logic [OffW-1:0]     ndef_offset;
    logic [LenW-1:0]     ndef_length;
  } result_t;

endpackage

[src/t2t_ntl_if.sv]
// valid/ready channel interfaces for image bytes and results
interface t2t_ntl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] mem_byte;
  logic       image_end;

  modport source(output valid, output mem_byte, output image_end, input ready);
  modport sink(input valid, input mem_byte, input image_end, output ready);
endinterface

interface t2t_ntl_out_if;
  logic                            valid;
  logic                            ready;
  t2t_ntl_pkg::status_t            status;
  logic                            ndef_found;
  logic [t2t_ntl_pkg::OffW-1:0]    ndef_offset;
  logic [t2t_ntl_pkg::LenW-1:0]    ndef_length;

  modport source(output valid, output status, output ndef_found, output ndef_offset,
                 output ndef_length, input ready);
  modport sink(input valid, input status, input ndef_found, input ndef_offset,
               input ndef_length, output ready);
endinterface

[src/t2t_ntl_parser.sv]
// per-byte tlv walker: state registers and the result decision
module t2t_ntl_parser #(
  parameter int MEM_BYTES = t2t_ntl_pkg::MemBytesDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [7:0]                    mem_byte,
  input  logic                          image_end,
  input  logic [t2t_ntl_pkg::LenW-1:0]  max_len,
  output logic                          res_valid,
  output t2t_ntl_pkg::result_t          res
);

  localparam int PosW = $clog2(MEM_BYTES + 1);
  localparam int OffW = t2t_ntl_pkg::OffW;
  localparam int LenW = t2t_ntl_pkg::LenW;

  typedef enum logic [5:0] {
    PH_HDR = 6'b000001,
    PH_TAG = 6'b000010,
    PH_LEN = 6'b000100,
    PH_LHI = 6'b001000,
    PH_LLO = 6'b010000,
    PH_VAL = 6'b100000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [7:0]        tag_r, tag_nxt;
  logic [LenW-1:0]   rem_r, rem_nxt;
  logic [7:0]        lhi_r, lhi_nxt;
  logic [OffW-1:0]   vstart_r, vstart_nxt;
  logic [LenW-1:0]   total_r, total_nxt;
  logic              big_r, big_nxt;
  logic              given_r, given_nxt;

  logic              walk;
  logic              do_begin;
  logic              do_finish;
  logic [LenW-1:0]   blen;
  logic [LenW-1:0]   rem_dec;
  logic [PosW-1:0]   pos_inc;

  assign walk    = !given_r && (pos_r < PosW'(MEM_BYTES));
  assign pos_inc = pos_r + PosW'(1);
  assign rem_dec = (rem_r == '0) ? '0 : rem_r - LenW'(1);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    tag_nxt    = tag_r;
    rem_nxt    = rem_r;
    lhi_nxt    = lhi_r;
    vstart_nxt = vstart_r;
    total_nxt  = total_r;
    big_nxt    = big_r;
    given_nxt  = given_r;
    do_begin   = 1'b0;
    do_finish  = 1'b0;
    blen       = {8'h00, mem_byte};
    res_valid  = 1'b0;
    res        = '0;

    if (step && walk) begin
      pos_nxt = pos_inc;
      case (phase_r)
        PH_HDR: begin
          if (pos_r >= PosW'(t2t_ntl_pkg::HdrBytes - 1)) phase_nxt = PH_TAG;
        end
        PH_TAG: begin
          if (mem_byte == t2t_ntl_pkg::TagTerm) begin
            res_valid = 1'b1;
            res.status = t2t_ntl_pkg::ST_OK;
          end else if (mem_byte != t2t_ntl_pkg::TagNull) begin
            tag_nxt   = mem_byte;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (mem_byte == t2t_ntl_pkg::LongLen) begin
            phase_nxt = PH_LHI;
          end else begin
            do_begin = 1'b1;
          end
        end
        PH_LHI: begin
          lhi_nxt   = mem_byte;
          phase_nxt = PH_LLO;
        end
        PH_LLO: begin
          blen = {lhi_r, mem_byte};
          if (blen < LenW'(t2t_ntl_pkg::LongLen)) begin
            res_valid  = 1'b1;
            res.status = t2t_ntl_pkg::ST_MALF;
          end else begin
            do_begin = 1'b1;
          end
        end
        PH_VAL: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) do_finish = 1'b1;
        end
        default: begin
        end
      endcase

      // length complete: latch value window and limit check
      if (do_begin) begin
        vstart_nxt = OffW'(pos_inc);
        total_nxt  = blen;
        rem_nxt    = blen;
        big_nxt    = (tag_r == t2t_ntl_pkg::TagNdef) && (max_len != '0) && (blen > max_len);
        if (blen == '0) begin
          do_finish = 1'b1;
        end else begin
          phase_nxt = PH_VAL;
        end
      end

      if (do_finish) begin
        if (tag_r == t2t_ntl_pkg::TagNdef) begin
          res_valid = 1'b1;
          if (big_nxt) begin
            res.status = t2t_ntl_pkg::ST_BIG;
          end else begin
            res.status      = t2t_ntl_pkg::ST_OK;
            res.ndef_found  = 1'b1;
            res.ndef_offset = (total_nxt != '0) ? vstart_nxt : '0;
            res.ndef_length = total_nxt;
          end
        end else begin
          phase_nxt = PH_TAG;
        end
      end

      if (res_valid) given_nxt = 1'b1;
    end

    // final byte closes the image
    if (step && image_end) begin
      if (!given_nxt) begin
        res_valid  = 1'b1;
        res        = '0;
        res.status = (phase_nxt == PH_TAG) ? t2t_ntl_pkg::ST_OK : t2t_ntl_pkg::ST_TRUNC;
      end
      phase_nxt  = PH_HDR;
      pos_nxt    = '0;
      tag_nxt    = '0;
      rem_nxt    = '0;
      lhi_nxt    = '0;
      vstart_nxt = '0;
      total_nxt  = '0;
      big_nxt    = 1'b0;
      given_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR;
      pos_r    <= '0;
      tag_r    <= '0;
      rem_r    <= '0;
      lhi_r    <= '0;
      vstart_r <= '0;
      total_r  <= '0;
      big_r    <= 1'b0;
      given_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      tag_r    <= tag_nxt;
      rem_r    <= rem_nxt;
      lhi_r    <= lhi_nxt;
      vstart_r <= vstart_nxt;
      total_r  <= total_nxt;
      big_r    <= big_nxt;
      given_r  <= given_nxt;
    end
  end

endmodule

[src/t2t_ntl_out_buf.sv]
// two-entry result buffer driving the result channel
module t2t_ntl_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  t2t_ntl_pkg::result_t   push_data,
  output logic                   room,
  t2t_ntl_out_if.source          out_ch
);

  t2t_ntl_pkg::result_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign room = (cnt_r != 2'd2);
  assign pop  = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.status      = ent_r[rd_ptr_r].status;
  assign out_ch.ndef_found  = ent_r[rd_ptr_r].ndef_found;
  assign out_ch.ndef_offset = ent_r[rd_ptr_r].ndef_offset;
  assign out_ch.ndef_length = ent_r[rd_ptr_r].ndef_length;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[src/t2t_ndef_tlv_locator_core.sv]
// the deciding byte waits in the input register and its result in the result buffer
// throughput: one image byte per cycle while the result buffer has room, else in_ch stalls
// the two-entry result buffer keeps bytes flowing while a result waits on out_ch
// reset: synchronous active-low rst_n clears the walker, the buffers and the size limit
// (limit reads as zero, no limit); no clearing pass, the block is ready right after reset
`include "t2t_ndef_tlv_locator_core_assert.svh"

module t2t_ndef_tlv_locator_core #(
  parameter int MEM_BYTES = t2t_ntl_pkg::MemBytesDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  t2t_ntl_in_if.sink                    in_ch,
  t2t_ntl_out_if.source                 out_ch,
  input  logic                          cfg_we,
  input  logic [t2t_ntl_pkg::LenW-1:0]  cfg_data
);

  // size limit register, zero means unlimited
  logic [t2t_ntl_pkg::LenW-1:0] max_len_r;

  // input register stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       in_xfer;
  logic       advance;

  // walker to buffer
  logic                 res_valid;
  t2t_ntl_pkg::result_t res;
  logic                 room;

  // result seen on out_ch, for the checks at the end
  logic out_not_ok;
  logic out_loc_zero;

  // the walker takes the held byte whenever the buffer has a free slot
  assign advance      = s1_valid_r && room;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_we) max_len_r <= cfg_data;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_ch.mem_byte;
      s1_end_r  <= in_ch.image_end;
    end
  end

  t2t_ntl_parser #(
    .MEM_BYTES(MEM_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .mem_byte (s1_byte_r),
    .image_end(s1_end_r),
    .max_len  (max_len_r),
    .res_valid(res_valid),
    .res      (res)
  );

  // at most one result per transfer, buffered toward out_ch
  t2t_ntl_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .room     (room),
    .out_ch   (out_ch)
  );

  assign out_not_ok   = out_ch.valid && (out_ch.status != t2t_ntl_pkg::ST_OK);
  assign out_loc_zero = !out_ch.ndef_found && (out_ch.ndef_offset == '0) &&
                        (out_ch.ndef_length == '0);

  // a result is only produced for a byte the walker actually took, into a free slot
  `T2T_NTL_ASSERT_IMP(a_push_has_room, res_valid, advance && room)
  // any status other than ok carries zero location fields
  `T2T_NTL_ASSERT_IMP(a_bad_status_zero, out_not_ok, out_loc_zero)
  // no ndef located means no length reported
  `T2T_NTL_ASSERT_IMP(a_absent_len_zero, out_ch.valid && !out_ch.ndef_found, out_ch.ndef_length == '0)

endmodule

[sim/tb_t2t_ndef_tlv_locator_core.sv]
// self-checking testbench for the t2t ndef tlv locator core
module tb_t2t_ndef_tlv_locator_core;

  // walker phases of the local predictor
  typedef enum int {
    WALK_HDR,
    WALK_TAG,
    WALK_LEN,
    WALK_LHI,
    WALK_LLO,
    WALK_VAL
  } walk_phase_t;

  // shapes of generated memory images
  typedef enum int {
    IMG_GOOD,
    IMG_PLAIN,
    IMG_CUT,
    IMG_BAD_LEN,
    IMG_NOISE,
    IMG_LONG
  } image_kind_t;

  // predicts one result per image and checks what the block delivers
  class ndef_scoreboard_t;
    logic [15:0]          size_limit;
    int                   pos;
    walk_phase_t          phase;
    logic [7:0]           tag;
    int                   remaining;
    logic [7:0]           len_hi;
    int                   val_start;
    int                   val_total;
    bit                   too_big;
    bit                   decided;
    t2t_ntl_pkg::result_t result_q[$];
    int                   errors;

    function new();
      size_limit = '0;
      errors = 0;
      clear_image();
    endfunction

    function void clear_image();
      pos = 0;
      phase = WALK_HDR;
      tag = '0;
      remaining = 0;
      len_hi = '0;
      val_start = 0;
      val_total = 0;
      too_big = 1'b0;
      decided = 1'b0;
    endfunction

    function void post(t2t_ntl_pkg::status_t st, logic found, int offset, int length);
      t2t_ntl_pkg::result_t r;
      r.status = st;
      r.ndef_found = found;
      r.ndef_offset = offset[t2t_ntl_pkg::OffW-1:0];
      r.ndef_length = length[t2t_ntl_pkg::LenW-1:0];
      result_q.push_back(r);
      decided = 1'b1;
    endfunction

    // only an ndef value ends the walk
    function void close_value();
      if (tag == t2t_ntl_pkg::TagNdef) begin
        if (too_big) post(t2t_ntl_pkg::ST_BIG, 1'b0, 0, 0);
        else post(t2t_ntl_pkg::ST_OK, 1'b1, (val_total != 0) ? val_start : 0, val_total);
      end else begin
        phase = WALK_TAG;
      end
    endfunction

    // limit is judged when the length is complete
    function void open_value(int length);
      val_start = pos + 1;
      val_total = length;
      remaining = length;
      too_big = (tag == t2t_ntl_pkg::TagNdef) && (size_limit != 0) && (length > size_limit);
      if (length == 0) close_value();
      else phase = WALK_VAL;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int long_len;
      if (!decided && pos < t2t_ntl_pkg::MemBytesDef) begin
        case (phase)
          WALK_HDR: begin
            if (pos + 1 >= t2t_ntl_pkg::HdrBytes) phase = WALK_TAG;
          end
          WALK_TAG: begin
            if (b == t2t_ntl_pkg::TagTerm) begin
              post(t2t_ntl_pkg::ST_OK, 1'b0, 0, 0);
            end else if (b != t2t_ntl_pkg::TagNull) begin
              tag = b;
              phase = WALK_LEN;
            end
          end
          WALK_LEN: begin
            if (b == t2t_ntl_pkg::LongLen) phase = WALK_LHI;
            else open_value(int'(b));
          end
          WALK_LHI: begin
            len_hi = b;
            phase = WALK_LLO;
          end
          WALK_LLO: begin
            long_len = int'({len_hi, b});
            if (long_len < t2t_ntl_pkg::LongLen) post(t2t_ntl_pkg::ST_MALF, 1'b0, 0, 0);
            else open_value(long_len);
          end
          default: begin
            if (remaining > 0) remaining--;
            if (remaining == 0) close_value();
          end
        endcase
        pos++;
      end
      if (last) begin
        if (!decided) begin
          post((phase == WALK_TAG) ? t2t_ntl_pkg::ST_OK : t2t_ntl_pkg::ST_TRUNC, 1'b0, 0, 0);
        end
        clear_image();
      end
    endfunction

    function void report(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(t2t_ntl_pkg::result_t got);
      t2t_ntl_pkg::result_t want;
      if (result_q.size() == 0) begin
        $error("result with none expected: status %0d found %0d offset %0d length %0d",
               got.status, got.ndef_found, got.ndef_offset, got.ndef_length);
        errors++;
      end else begin
        want = result_q.pop_front();
        report("status", want.status, got.status);
        report("ndef_found", want.ndef_found, got.ndef_found);
        report("ndef_offset", want.ndef_offset, got.ndef_offset);
        report("ndef_length", want.ndef_length, got.ndef_length);
      end
    endfunction

    function int outstanding();
      return result_q.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [t2t_ntl_pkg::LenW-1:0] cfg_data;

  t2t_ntl_in_if  in_ch();
  t2t_ntl_out_if out_ch();

  ndef_scoreboard_t sb;
  logic [7:0]       img_bytes[$];
  bit               calm;   // final stretch: no idling on either side
  int               sent;   // accepted image bytes that count toward the run length

  t2t_ndef_tlv_locator_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watch both channels; an input can not decide a result visible at the same edge
  always @(posedge clk) begin : watch
    t2t_ntl_pkg::result_t seen;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_byte(in_ch.mem_byte, in_ch.image_end);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.status = out_ch.status;
      seen.ndef_found = out_ch.ndef_found;
      seen.ndef_offset = out_ch.ndef_offset;
      seen.ndef_length = out_ch.ndef_length;
      sb.check_result(seen);
    end
  end

  // result side: ready runs broken by random stalls, none once calm is set
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!calm) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // any tag that is neither null, terminator nor ndef
  function automatic logic [7:0] other_tag();
    logic [7:0] t;
    do t = 8'($urandom_range(0, 255));
    while (t == t2t_ntl_pkg::TagNull || t == t2t_ntl_pkg::TagTerm ||
           t == t2t_ntl_pkg::TagNdef);
    return t;
  endfunction

  function automatic void add_header();
    repeat (t2t_ntl_pkg::HdrBytes) img_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_junk(int count);
    repeat (count) img_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // short form only up to 254, long form only from 255
  function automatic void add_tlv(logic [7:0] tag, int length);
    img_bytes.push_back(tag);
    if (length >= 255) begin
      img_bytes.push_back(t2t_ntl_pkg::LongLen);
      img_bytes.push_back(length[15:8]);
      img_bytes.push_back(length[7:0]);
    end else begin
      img_bytes.push_back(length[7:0]);
    end
    add_junk(length);
  endfunction

  // nulls and foreign tlvs ahead of the interesting part
  function automatic void add_filler(int count);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: img_bytes.push_back(t2t_ntl_pkg::TagNull);
        1, 2: add_tlv(other_tag(), $urandom_range(0, 12));
        default: begin
          if ($urandom_range(0, 9) == 0) add_tlv(other_tag(), $urandom_range(255, 270));
          else add_tlv(other_tag(), $urandom_range(0, 3));
        end
      endcase
    end
  endfunction

  // mostly short values, some empty, some long form
  function automatic int ndef_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r < 8) return $urandom_range(1, 40);
    return $urandom_range(255, 300);
  endfunction

  function automatic void make_image(image_kind_t kind);
    int keep;
    int target;
    img_bytes.delete();
    case (kind)
      IMG_GOOD: begin
        add_header();
        add_filler($urandom_range(0, 3));
        add_tlv(t2t_ntl_pkg::TagNdef, ndef_size());
        add_junk($urandom_range(0, 3));
      end
      IMG_PLAIN: begin
        // no ndef: either a terminator or an end on a tag boundary
        add_header();
        add_filler($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) begin
          img_bytes.push_back(t2t_ntl_pkg::TagTerm);
          add_junk($urandom_range(0, 3));
        end
      end
      IMG_CUT: begin
        add_header();
        if ($urandom_range(0, 4) == 0) begin
          // largest long-form length, never completes
          img_bytes.push_back(t2t_ntl_pkg::TagNdef);
          img_bytes.push_back(t2t_ntl_pkg::LongLen);
          img_bytes.push_back(8'hFF);
          img_bytes.push_back(8'hFF);
          add_junk($urandom_range(0, 6));
        end else begin
          add_filler($urandom_range(0, 2));
          add_tlv(t2t_ntl_pkg::TagNdef, ndef_size());
          keep = $urandom_range(1, img_bytes.size() - 1);
          while (img_bytes.size() > keep) void'(img_bytes.pop_back());
        end
      end
      IMG_BAD_LEN: begin
        // long form below 255, 254 is the edge
        add_header();
        add_filler($urandom_range(0, 2));
        img_bytes.push_back(($urandom_range(0, 1) == 1) ? t2t_ntl_pkg::TagNdef : other_tag());
        img_bytes.push_back(t2t_ntl_pkg::LongLen);
        img_bytes.push_back(8'h00);
        img_bytes.push_back(($urandom_range(0, 1) == 1) ? 8'd254 : 8'($urandom_range(0, 253)));
        add_junk($urandom_range(0, 3));
      end
      IMG_NOISE: begin
        add_junk($urandom_range(1, 50));
      end
      default: begin
        // past the walked window: ndef near the top, may cross it
        add_header();
        target = $urandom_range(1980, 2040);
        while (img_bytes.size() < target) add_filler(1);
        add_tlv(t2t_ntl_pkg::TagNdef, $urandom_range(0, 30));
        while (img_bytes.size() < t2t_ntl_pkg::MemBytesDef + 20) add_junk(1);
      end
    endcase
  endfunction

  function automatic image_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return IMG_GOOD;
    if (r < 60) return IMG_PLAIN;
    if (r < 75) return IMG_CUT;
    if (r < 85) return IMG_BAD_LEN;
    return IMG_NOISE;
  endfunction

  // one byte transfer, with an optional idle gap ahead of it
  task automatic push_byte(logic [7:0] b, logic last, bit steady);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mem_byte <= b;
    in_ch.image_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_image();
    bit steady;
    steady = calm || ($urandom_range(0, 3) == 0);
    foreach (img_bytes[i]) push_byte(img_bytes[i], i == img_bytes.size() - 1, steady);
  endtask

  // hold the sender until every result is in, then let the pipeline empty
  task automatic drain();
    int w;
    in_ch.valid <= 1'b0;
    for (w = 0; sb.outstanding() != 0 && w < 4000; w++) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d expected results never arrived", sb.outstanding());
      sb.errors++;
      sb.result_q.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [t2t_ntl_pkg::LenW-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.size_limit = value;
  endtask

  initial begin
    logic [t2t_ntl_pkg::LenW-1:0] plan[7];
    int                           goal;
    int                           keep_sent;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mem_byte = '0;
    in_ch.image_end = 1'b0;
    calm = 1'b0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // image ending inside the header
    push_byte(8'hFF, 1'b1, 1'b0);
    // full header, a null, then an empty ndef, then an ignored final byte
    for (int i = 0; i < t2t_ntl_pkg::HdrBytes; i++) begin
      push_byte((i % 2 == 1) ? 8'hFF : 8'h00, 1'b0, 1'b0);
    end
    push_byte(t2t_ntl_pkg::TagNull, 1'b0, 1'b0);
    push_byte(t2t_ntl_pkg::TagNdef, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h5A, 1'b1, 1'b0);

    // limit settings per phase, extremes included
    plan[0] = '0;
    plan[1] = 16'd1;
    plan[2] = 16'hFFFF;
    plan[3] = 16'($urandom_range(2, 40));
    plan[4] = 16'd255;
    plan[5] = 16'($urandom_range(0, 65535));
    plan[6] = 16'($urandom_range(2, 300));

    for (int p = 0; p < 7; p++) begin
      drain();
      write_limit(plan[p]);
      if (p == 4) begin
        // two images past the walked window, not counted toward the run length
        keep_sent = sent;
        repeat (2) begin
          make_image(IMG_LONG);
          send_image();
        end
        sent = keep_sent;
      end
      if (p == 6) calm = 1'b1;
      goal = sent + 250;
      while (sent < goal) begin
        make_image(pick_kind());
        send_image();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("t2t_ndef_tlv_locator_core test passed");
    end else begin
      $display("t2t_ndef_tlv_locator_core test failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("t2t_ndef_tlv_locator_core test failed");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/t2t_ntl_pkg.sv
src/t2t_ntl_if.sv
src/t2t_ntl_parser.sv
src/t2t_ntl_out_buf.sv
src/t2t_ndef_tlv_locator_core.sv
sim/tb_t2t_ndef_tlv_locator_core.sv
